// ===== hw/rtl/log_line_severity_classifier_top_defines.svh =====
// Assertion macros shared by the severity classifier checker.
`ifndef LOG_LINE_SEVERITY_CLASSIFIER_TOP_DEFINES_SVH
`define LOG_LINE_SEVERITY_CLASSIFIER_TOP_DEFINES_SVH

// Check while out of reset.
`define LLSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check at every edge, reset included.
`define LLSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/llsc_pkg.sv =====
// Types, keyword constants and match functions for the severity classifier.
package llsc_pkg;

  typedef logic [2:0] level_t;

  localparam level_t LVL_UNKNOWN  = 3'd0;
  localparam level_t LVL_DEBUG    = 3'd1;
  localparam level_t LVL_INFO     = 3'd2;
  localparam level_t LVL_WARNING  = 3'd3;
  localparam level_t LVL_ERROR    = 3'd4;
  localparam level_t LVL_CRITICAL = 3'd5;

  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CASE_MASK   = 8'hDF;

  localparam logic [3:0] TAG_BYTES = 4'd8;
  localparam logic [3:0] TAG_SAT   = 4'd9;

  // Keywords packed right-justified, first letter in the highest used byte.
  localparam logic [63:0] KW_CRITICAL = 64'h4352_4954_4943_414C;
  localparam logic [31:0] KW_CRIT     = 32'h4352_4954;
  localparam logic [39:0] KW_ERROR    = 40'h45_5252_4F52;
  localparam logic [23:0] KW_ERR      = 24'h45_5252;
  localparam logic [55:0] KW_WARNING  = 56'h57_4152_4E49_4E47;
  localparam logic [31:0] KW_WARN     = 32'h5741_524E;
  localparam logic [31:0] KW_INFO     = 32'h494E_464F;
  localparam logic [39:0] KW_DEBUG    = 40'h44_4542_5547;
  localparam logic [23:0] KW_DBG      = 24'h44_4247;

  typedef struct packed {
    logic       take;   // byte belongs to the examined text
    logic       clear;  // line ends after this byte
    logic [7:0] ch;     // upper-case folded byte
  } llsc_ctrl_t;

  // Severity of a complete tag, zero if it is no keyword.
  function automatic level_t tag_level(input logic [63:0] text, input logic [3:0] len);
    level_t lvl;
    lvl = LVL_UNKNOWN;
    if (len == 4'd8 && text == KW_CRITICAL)                lvl = LVL_CRITICAL;
    else if (len == 4'd4 && text == {32'd0, KW_CRIT})      lvl = LVL_CRITICAL;
    else if (len == 4'd5 && text == {24'd0, KW_ERROR})     lvl = LVL_ERROR;
    else if (len == 4'd3 && text == {40'd0, KW_ERR})       lvl = LVL_ERROR;
    else if (len == 4'd7 && text == {8'd0, KW_WARNING})    lvl = LVL_WARNING;
    else if (len == 4'd4 && text == {32'd0, KW_WARN})      lvl = LVL_WARNING;
    else if (len == 4'd4 && text == {32'd0, KW_INFO})      lvl = LVL_INFO;
    else if (len == 4'd5 && text == {24'd0, KW_DEBUG})     lvl = LVL_DEBUG;
    else if (len == 4'd3 && text == {40'd0, KW_DBG})       lvl = LVL_DEBUG;
    return lvl;
  endfunction

  // Highest level flagged in a seen mask, bit L-1 for level L.
  function automatic level_t highest_level(input logic [4:0] seen);
    level_t lvl;
    lvl = LVL_UNKNOWN;
    if (seen[4])      lvl = LVL_CRITICAL;
    else if (seen[3]) lvl = LVL_ERROR;
    else if (seen[2]) lvl = LVL_WARNING;
    else if (seen[1]) lvl = LVL_INFO;
    else if (seen[0]) lvl = LVL_DEBUG;
    return lvl;
  endfunction

endpackage

// ===== hw/rtl/llsc_if.sv =====
// Stream interfaces for the log bytes in and the severity results out.
interface llsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface llsc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] level;
  logic       from_tag;

  modport source (output valid, output level, output from_tag, input ready);
  modport sink   (input valid, input level, input from_tag, output ready);
endinterface

// ===== hw/rtl/log_line_severity_classifier_top.sv =====
// Log line severity classifier: input register, scan units, result register.
// Flow: a transferred byte sits in the input register and is processed by the scan units;
//   the result of a line's last byte goes into the result register and can transfer from there.
// Throughput: one byte per cycle while no waiting result stalls a line end.
// A waiting result stalls the input only when the next byte is also a line end.
// Reset clears the line state, the stage valids and the result valid at once.
module log_line_severity_classifier_top #(
  parameter int MAX_LEN = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  llsc_in_if.sink     in_i,
  llsc_out_if.source  out_o
);

  localparam int CNT_W = $clog2(MAX_LEN);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN - 1);

  logic             s1_valid_q;
  logic [7:0]       s1_ch_q;
  logic             s1_last_q;
  logic             stall;
  logic             fire;
  logic             in_xfer;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ended_q, ended_d;
  logic [7:0]       ch_up;
  logic             live;

  llsc_pkg::llsc_ctrl_t ctrl;
  llsc_pkg::level_t     tag_lvl;
  logic [4:0]           seen;
  llsc_pkg::level_t     res_level;
  logic                 res_from_tag;

  logic                 out_valid_q;
  llsc_pkg::level_t     out_level_q;
  logic                 out_from_tag_q;

  // Hold the input stage only when its line end cannot enter a full result register.
  assign stall   = s1_valid_q && s1_last_q && out_valid_q && !out_o.ready;
  assign fire    = s1_valid_q && !stall;
  assign in_i.ready = !s1_valid_q || !stall;
  assign in_xfer = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_ch_q   <= in_i.ch;
      s1_last_q <= in_i.last;
    end
  end

  // Fold lower case letters to upper case.
  assign ch_up = (s1_ch_q >= llsc_pkg::CH_LOWER_A && s1_ch_q <= llsc_pkg::CH_LOWER_Z)
                 ? (s1_ch_q & llsc_pkg::CASE_MASK) : s1_ch_q;

  assign live = fire && !ended_q && (cnt_q != CNT_MAX);

  always_comb begin
    cnt_d   = cnt_q;
    ended_d = ended_q;
    if (live) begin
      if (s1_ch_q == llsc_pkg::CH_NUL) begin
        ended_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  assign ctrl.take  = live && (s1_ch_q != llsc_pkg::CH_NUL);
  assign ctrl.clear = fire && s1_last_q;
  assign ctrl.ch    = ch_up;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ended_q <= 1'b0;
    end else if (ctrl.clear) begin
      cnt_q   <= '0;
      ended_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      ended_q <= ended_d;
    end
  end

  llsc_tag_scan u_tag_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .level_o (tag_lvl)
  );

  llsc_kw_detect u_kw_detect (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .seen_o (seen)
  );

  assign res_from_tag = (tag_lvl != llsc_pkg::LVL_UNKNOWN);
  assign res_level    = res_from_tag ? tag_lvl : llsc_pkg::highest_level(seen);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.clear) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.clear) begin
      out_level_q    <= res_level;
      out_from_tag_q <= res_from_tag;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.level    = out_level_q;
  assign out_o.from_tag = out_from_tag_q;

endmodule

// ===== hw/rtl/llsc_tag_scan.sv =====
// Bracketed tag scanner: tracks the open tag and latches the first matching one.
module llsc_tag_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  llsc_pkg::llsc_ctrl_t ctrl_i,
  output llsc_pkg::level_t    level_o
);

  logic [63:0]       text_q, text_d;
  logic [3:0]        len_q, len_d;
  logic              inside_q, inside_d;
  logic              over_q, over_d;
  llsc_pkg::level_t  lvl_q, lvl_d;
  llsc_pkg::level_t  match_lvl;

  assign match_lvl = llsc_pkg::tag_level(text_q, len_q);

  always_comb begin
    text_d   = text_q;
    len_d    = len_q;
    inside_d = inside_q;
    over_d   = over_q;
    lvl_d    = lvl_q;
    if (ctrl_i.take && !over_q) begin
      if (inside_q) begin
        if (ctrl_i.ch == llsc_pkg::CH_RBRACKET) begin
          if (match_lvl != llsc_pkg::LVL_UNKNOWN) begin
            lvl_d  = match_lvl;
            over_d = 1'b1;
          end
          inside_d = 1'b0;
          text_d   = '0;
          len_d    = '0;
        end else if (len_q < llsc_pkg::TAG_SAT) begin
          if (len_q < llsc_pkg::TAG_BYTES) begin
            text_d = {text_q[55:0], ctrl_i.ch};
          end
          len_d = len_q + 4'd1;
        end
      end else if (ctrl_i.ch == llsc_pkg::CH_LBRACKET) begin
        inside_d = 1'b1;
        text_d   = '0;
        len_d    = '0;
      end
    end
  end

  // The result sees this byte's update; the line end then clears everything.
  assign level_o = lvl_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_q   <= '0;
      len_q    <= '0;
      inside_q <= 1'b0;
      over_q   <= 1'b0;
      lvl_q    <= llsc_pkg::LVL_UNKNOWN;
    end else if (ctrl_i.clear) begin
      text_q   <= '0;
      len_q    <= '0;
      inside_q <= 1'b0;
      over_q   <= 1'b0;
      lvl_q    <= llsc_pkg::LVL_UNKNOWN;
    end else begin
      text_q   <= text_d;
      len_q    <= len_d;
      inside_q <= inside_d;
      over_q   <= over_d;
      lvl_q    <= lvl_d;
    end
  end

endmodule

// ===== hw/rtl/llsc_kw_detect.sv =====
// Keyword detector: sliding window of recent bytes, flags each level seen.
module llsc_kw_detect (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  llsc_pkg::llsc_ctrl_t ctrl_i,
  output logic [4:0]           seen_o
);

  // Four earlier bytes suffice: CRITICAL, ERROR and WARNING begin with a shorter keyword; DEBUG fits in five.
  logic [31:0] win_q, win_d;
  logic [4:0]  seen_q, seen_d;
  logic [39:0] cur;
  logic [4:0]  hits;

  assign cur = {win_q, ctrl_i.ch};

  always_comb begin
    hits = '0;
    if (cur[31:0] == llsc_pkg::KW_CRIT) hits[4] = 1'b1;
    if (cur[23:0] == llsc_pkg::KW_ERR)  hits[3] = 1'b1;
    if (cur[31:0] == llsc_pkg::KW_WARN) hits[2] = 1'b1;
    if (cur[31:0] == llsc_pkg::KW_INFO) hits[1] = 1'b1;
    if (cur[23:0] == llsc_pkg::KW_DBG || cur == llsc_pkg::KW_DEBUG) hits[0] = 1'b1;
  end

  always_comb begin
    win_d  = win_q;
    seen_d = seen_q;
    if (ctrl_i.take) begin
      win_d  = cur[31:0];
      seen_d = seen_q | hits;
    end
  end

  assign seen_o = seen_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      seen_q <= '0;
    end else if (ctrl_i.clear) begin
      win_q  <= '0;
      seen_q <= '0;
    end else begin
      win_q  <= win_d;
      seen_q <= seen_d;
    end
  end

endmodule

// ===== hw/rtl/llsc_checker.sv =====
// Port-level checks on the classifier's result channel, bound to the top level.
`include "log_line_severity_classifier_top_defines.svh"

module llsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_level_i,
  input logic       out_from_tag_i
);

  `LLSC_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_level_i) && $stable(out_from_tag_i), "result changed while stalled")
  `LLSC_ASSERT(a_level_range, out_valid_i |-> out_level_i <= llsc_pkg::LVL_CRITICAL, "level out of range")
  `LLSC_ASSERT(a_tag_level, out_valid_i && out_from_tag_i |-> out_level_i != llsc_pkg::LVL_UNKNOWN, "tag result with unknown level")
  `LLSC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_i || $past(rst_ni), "result valid right after reset")

endmodule

bind log_line_severity_classifier_top llsc_checker u_llsc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_level_i    (out_o.level),
  .out_from_tag_i (out_o.from_tag)
);

// ===== verif/tb.sv =====
// Stream testbench for the log line severity classifier, self-checking against a local predictor.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_LEN = 1024;
  localparam int LONG_HOLD = 400;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 150;
  localparam string LETTERS = "CRITALEOWNGFDBUXcriterwaningdbg _:";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } line_byte_t;

  typedef struct packed {
    llsc_pkg::level_t level;
    logic             from_tag;
  } severity_t;

  typedef struct packed {
    logic [63:0]      text;
    logic [3:0]       len;
    llsc_pkg::level_t lvl;
  } keyword_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKED} rx_mode_e;

  localparam keyword_t KEYWORDS [9] = '{
    '{llsc_pkg::KW_CRITICAL, 4'd8, llsc_pkg::LVL_CRITICAL},
    '{{32'd0, llsc_pkg::KW_CRIT}, 4'd4, llsc_pkg::LVL_CRITICAL},
    '{{24'd0, llsc_pkg::KW_ERROR}, 4'd5, llsc_pkg::LVL_ERROR},
    '{{40'd0, llsc_pkg::KW_ERR}, 4'd3, llsc_pkg::LVL_ERROR},
    '{{8'd0, llsc_pkg::KW_WARNING}, 4'd7, llsc_pkg::LVL_WARNING},
    '{{32'd0, llsc_pkg::KW_WARN}, 4'd4, llsc_pkg::LVL_WARNING},
    '{{32'd0, llsc_pkg::KW_INFO}, 4'd4, llsc_pkg::LVL_INFO},
    '{{24'd0, llsc_pkg::KW_DEBUG}, 4'd5, llsc_pkg::LVL_DEBUG},
    '{{40'd0, llsc_pkg::KW_DBG}, 4'd3, llsc_pkg::LVL_DEBUG}
  };

  string kw_words [9] = '{"CRITICAL", "CRIT", "ERROR", "ERR", "WARNING", "WARN", "INFO",
                          "DEBUG", "DBG"};

  logic clk_i;
  logic rst_ni;

  llsc_in_if  in_bus();
  llsc_out_if out_bus();

  log_line_severity_classifier_top #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Stimulus and expectation stores
  line_byte_t  pending_bytes[$];
  logic [7:0]  line_buf[$];
  severity_t   expected_severity[$];
  int          queued_count;
  int          error_count;
  int          results_seen;
  int          idle_cycles;
  int          hold_requests;
  logic        in_fire;

  // Predictor state for the line in progress
  logic [63:0]      cur_tag_text;
  logic [3:0]       cur_tag_len;
  logic             tag_open;
  logic             tag_hit;
  llsc_pkg::level_t tag_hit_level;
  logic [55:0]      recent_bytes;
  logic [4:0]       kw_seen;
  int unsigned      text_len;
  logic             text_done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want, results_seen);
    error_count++;
  endtask

  // Advance the predictor by one accepted byte; queue a severity on a line end.
  task automatic classify_byte(input logic [7:0] raw, input logic last);
    logic [7:0]  c;
    logic [55:0] mask;
    severity_t   res;
    c = raw;
    if (!text_done && text_len < MAX_LEN - 1) begin
      if (c == llsc_pkg::CH_NUL) begin
        text_done = 1'b1;
      end else begin
        if (c >= llsc_pkg::CH_LOWER_A && c <= llsc_pkg::CH_LOWER_Z) c = c - 8'd32;
        if (!tag_hit) begin
          if (tag_open) begin
            if (c == llsc_pkg::CH_RBRACKET) begin
              for (int i = 0; i < 9; i++) begin
                if (!tag_hit && cur_tag_len == KEYWORDS[i].len &&
                    cur_tag_text == KEYWORDS[i].text) begin
                  tag_hit = 1'b1;
                  tag_hit_level = KEYWORDS[i].lvl;
                end
              end
              tag_open = 1'b0;
              cur_tag_text = '0;
              cur_tag_len = '0;
            end else if (cur_tag_len < llsc_pkg::TAG_SAT) begin
              if (cur_tag_len < llsc_pkg::TAG_BYTES) cur_tag_text = {cur_tag_text[55:0], c};
              cur_tag_len = cur_tag_len + 4'd1;
            end
          end else if (c == llsc_pkg::CH_LBRACKET) begin
            tag_open = 1'b1;
            cur_tag_text = '0;
            cur_tag_len = '0;
          end
        end
        recent_bytes = {recent_bytes[47:0], c};
        // Long keywords are covered by their shorter prefixes
        for (int i = 0; i < 9; i++) begin
          if (KEYWORDS[i].len <= 5) begin
            mask = (56'd1 << (8 * KEYWORDS[i].len)) - 56'd1;
            if ((recent_bytes & mask) == KEYWORDS[i].text[55:0] && text_len + 1 >= KEYWORDS[i].len)
              kw_seen[KEYWORDS[i].lvl - 3'd1] = 1'b1;
          end
        end
        text_len++;
      end
    end
    if (last) begin
      if (tag_hit) begin
        res.level = tag_hit_level;
        res.from_tag = 1'b1;
      end else begin
        res.level = llsc_pkg::LVL_UNKNOWN;
        res.from_tag = 1'b0;
        for (int b = 4; b >= 0; b--)
          if (kw_seen[b] && res.level == llsc_pkg::LVL_UNKNOWN)
            res.level = llsc_pkg::level_t'(b + 1);
      end
      expected_severity.push_back(res);
      cur_tag_text = '0;
      cur_tag_len = '0;
      tag_open = 1'b0;
      tag_hit = 1'b0;
      tag_hit_level = llsc_pkg::LVL_UNKNOWN;
      recent_bytes = '0;
      kw_seen = '0;
      text_len = 0;
      text_done = 1'b0;
    end
  endtask

  // Append text to the line under construction, optionally with random lower case.
  task automatic add_text(input string s, input bit mixed);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mixed && c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1)) c = c + 8'd32;
      line_buf.push_back(c);
    end
  endtask

  function automatic logic [7:0] random_letter();
    return LETTERS[$urandom_range(0, LETTERS.len() - 1)];
  endfunction

  task automatic commit_line();
    if (line_buf.size() == 0) line_buf.push_back(8'($urandom_range(0, 255)));
    foreach (line_buf[i]) pending_bytes.push_back('{line_buf[i], i == line_buf.size() - 1});
    queued_count += line_buf.size();
    line_buf.delete();
  endtask

  task automatic build_random_line(input int pieces);
    string word;
    for (int p = 0; p < pieces; p++) begin
      word = kw_words[$urandom_range(0, 8)];
      case ($urandom_range(0, 11))
        0, 1, 2: add_text(word, 1);
        3, 4, 5: begin
          line_buf.push_back(llsc_pkg::CH_LBRACKET);
          case ($urandom_range(0, 5))
            0, 1, 2: add_text(word, 1);
            3: begin
              add_text(word, 1);
              repeat ($urandom_range(1, 6)) line_buf.push_back(random_letter());
            end
            4: repeat ($urandom_range(0, 10)) line_buf.push_back(random_letter());
            default: add_text(word.substr(0, $urandom_range(0, word.len() - 1)), 1);
          endcase
          if ($urandom_range(0, 7) != 0) line_buf.push_back(llsc_pkg::CH_RBRACKET);
        end
        6: line_buf.push_back(llsc_pkg::CH_LBRACKET);
        7: line_buf.push_back(llsc_pkg::CH_RBRACKET);
        8, 9: repeat ($urandom_range(1, 5)) line_buf.push_back(random_letter());
        10: repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
        default: line_buf.push_back($urandom_range(0, 3) == 0 ? llsc_pkg::CH_NUL : 8'h20);
      endcase
    end
    commit_line();
  endtask

  // Sample at the rising edge, where valid and the queues are settled.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_bytes.size() != 0 || in_bus.valid || expected_severity.size() != 0);
  endtask

  // Byte driver: bursts of random length separated by random gaps
  int burst_left;
  int gap_left;

  always @(negedge clk_i) begin : drive_bytes
    line_byte_t item;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (pending_bytes.size() == 0) begin
        in_bus.valid <= 1'b0;
      end else begin
        item = pending_bytes.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.ch <= item.ch;
        in_bus.last <= item.last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Result receiver: randomly chosen stall pattern; long hold on request
  rx_mode_e rx_mode;
  int       rx_cycle;
  int       holds_granted;
  int       hold_left;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 50 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      if (holds_granted != hold_requests) begin
        holds_granted = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   out_bus.ready <= 1'b1;
          RX_COIN:   out_bus.ready <= $urandom_range(0, 1);
          RX_SPARSE: out_bus.ready <= (rx_cycle % 4 == 0);
          default:   out_bus.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Monitor: check results, predict accepted bytes, watch for a hang
  always @(posedge clk_i) begin : monitor
    severity_t want;
    logic      out_fire;
    logic      byte_fire;
    out_fire = rst_ni && out_bus.valid && out_bus.ready;
    byte_fire = rst_ni && in_bus.valid && in_bus.ready;
    if (out_fire) begin
      if (expected_severity.size() == 0) begin
        report_mismatch("result with none pending, level", out_bus.level,
                        llsc_pkg::LVL_UNKNOWN);
      end else begin
        want = expected_severity.pop_front();
        if (out_bus.level !== want.level)
          report_mismatch("level", out_bus.level, want.level);
        if (out_bus.from_tag !== want.from_tag)
          report_mismatch("from_tag", out_bus.from_tag, want.from_tag);
      end
      results_seen++;
    end
    if (byte_fire) classify_byte(in_bus.ch, in_bus.last);
    in_fire <= byte_fire;
    if (!rst_ni || out_fire || byte_fire) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.ch = '0;
    in_bus.last = 1'b0;
    out_bus.ready = 1'b0;
    in_fire = 1'b0;
    rx_mode = RX_OPEN;
    cur_tag_text = '0;
    cur_tag_len = '0;
    tag_open = 1'b0;
    tag_hit = 1'b0;
    tag_hit_level = llsc_pkg::LVL_UNKNOWN;
    recent_bytes = '0;
    kw_seen = '0;
    text_len = 0;
    text_done = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed lines: exact tag in lower case, empty tag, bracket inside an
    // unclosed tag, single-byte lines, text cut short by a zero byte
    add_text("[dbg]", 0);
    commit_line();
    add_text("[]Err", 0);
    commit_line();
    add_text("[[Info", 0);
    commit_line();
    line_buf.push_back(8'hFF);
    commit_line();
    line_buf.push_back(llsc_pkg::CH_NUL);
    commit_line();
    add_text("ER", 0);
    line_buf.push_back(llsc_pkg::CH_NUL);
    add_text("R", 0);
    commit_line();
    wait_drained();

    // Random lines, with one overlong line in the middle
    queued_count = 0;
    while (queued_count < RANDOM_ITEMS / 2) build_random_line($urandom_range(1, 6));
    // Close the tag and add a keyword only past the length limit
    repeat (MAX_LEN - 12) line_buf.push_back(random_letter());
    add_text("[ERR", 1);
    repeat (8) line_buf.push_back(random_letter());
    line_buf.push_back(llsc_pkg::CH_RBRACKET);
    add_text("CRITICAL", 1);
    commit_line();
    queued_count = 0;
    while (queued_count < RANDOM_ITEMS / 3) build_random_line($urandom_range(1, 6));
    wait_drained();

    // Hold the receiver while short lines keep coming, then let it all drain
    @(posedge clk_i);
    hold_requests++;
    repeat (80) build_random_line($urandom_range(0, 1));
    wait_drained();

    queued_count = 0;
    while (queued_count < RANDOM_ITEMS / 4) build_random_line($urandom_range(1, 8));
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (expected_severity.size() != 0)
      report_mismatch("results never seen", expected_severity.size(), 0);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
